// ===== hdl/iddn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iddn_pkg
// Shared constants and types of the isotropic diffusion denoise unit.
// ---------------------------------------------------------------------------
package iddn_pkg;

    localparam int MAX_ROWS_DEF  = 512;
    localparam int MAX_COLS_DEF  = 512;
    localparam int FRAC_BITS_DEF = 12;

    localparam int OP_W   = 2;
    localparam int ROW_W  = 9;
    localparam int COL_W  = 9;
    localparam int PIX_W  = 8;
    localparam int CIDX_W = 4;
    localparam int CDAT_W = 16;

    localparam int KAPPA_W = 15;
    localparam int ITER_W  = 10;
    localparam int SIZE_W  = 10;

    localparam logic [KAPPA_W-1:0] KAPPA_MAX   = 15'd16384;
    localparam logic [KAPPA_W-1:0] KAPPA_RESET = 15'd1638;
    localparam logic [ITER_W-1:0]  ITER_RESET  = 10'd10;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 10'd512;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_KAPPA = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_ITER  = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_ROWS  = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_COLS  = 4'd3;

    // Control of the two frame stores; addresses and data travel beside it.
    typedef struct packed {
        logic rd_en;
        logic rd_b;
        logic wr_en;
        logic wr_b;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== hdl/iddn_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iddn_ifs
// Command, result and configuration channels of the denoise unit.
// ---------------------------------------------------------------------------
interface iddn_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [iddn_pkg::OP_W-1:0]  op;
    logic [iddn_pkg::ROW_W-1:0] row;
    logic [iddn_pkg::COL_W-1:0] col;
    logic [iddn_pkg::PIX_W-1:0] pixel_in;
    modport source (output valid, op, row, col, pixel_in, input ready);
    modport sink   (input valid, op, row, col, pixel_in, output ready);
endinterface

interface iddn_res_if;
    logic                       valid;
    logic                       ready;
    logic [iddn_pkg::PIX_W-1:0] pixel_out;
    logic                       done_res;
    logic                       addr_error;
    modport source (output valid, pixel_out, done_res, addr_error, input ready);
    modport sink   (input valid, pixel_out, done_res, addr_error, output ready);
endinterface

interface iddn_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [iddn_pkg::CIDX_W-1:0] index;
    logic [iddn_pkg::CDAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/iso_diffusion_denoise_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iso_diffusion_denoise_unit
// Frame-store based five-point isotropic diffusion denoiser.
// ---------------------------------------------------------------------------
// Load and read commands take one beat each (a read answers once the registered
// store read has been captured in the output register). A run command walks the
// configured frame once per pass, for the configured number of passes, with a
// single store read port: an interior pixel issues its five stencil reads, waits
// for the read data, multiplies and writes; a border pixel issues one read, waits
// and writes its value unchanged. Results are held in an output register; the
// next command is taken once it empties.
module iso_diffusion_denoise_unit #(
    parameter int MAX_ROWS  = iddn_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = iddn_pkg::MAX_COLS_DEF,
    parameter int FRAC_BITS = iddn_pkg::FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    iddn_cmd_if.sink    i_cmd,
    iddn_res_if.source  o_res,
    iddn_cfg_if.sink    i_cfg
);
    import iddn_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DW     = 8 + FRAC_BITS;

    t_mem_ctl          ctl;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [DW-1:0]     wr_data, rd_data;

    iddn_ctrl #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS),
        .ADDR_W(ADDR_W), .DW(DW)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(i_cmd), .o_res(o_res), .i_cfg(i_cfg),
        .o_ctl(ctl), .o_rd_addr(rd_addr), .o_wr_addr(wr_addr),
        .o_wr_data(wr_data), .i_rd_data(rd_data)
    );

    iddn_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DW(DW)) u_store (
        .i_clk(i_clk), .i_ctl(ctl), .i_rd_addr(rd_addr), .i_wr_addr(wr_addr),
        .i_wr_data(wr_data), .o_rd_data(rd_data)
    );

endmodule

`default_nettype wire

// ===== hdl/iddn_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iddn_store
// The two ping-pong frame stores, each one write and one registered read.
// ---------------------------------------------------------------------------
module iddn_store #(
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = 18,
    parameter int DW     = 20
) (
    input  wire                     i_clk,
    input  iddn_pkg::t_mem_ctl      i_ctl,
    input  wire  [ADDR_W-1:0]       i_rd_addr,
    input  wire  [ADDR_W-1:0]       i_wr_addr,
    input  wire  [DW-1:0]           i_wr_data,
    output logic [DW-1:0]           o_rd_data
);
    import iddn_pkg::*;

    logic [DW-1:0] mem_a [DEPTH];
    logic [DW-1:0] mem_b [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;
    logic          r_sel_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && !i_ctl.wr_b) begin
            mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en && !i_ctl.rd_b) begin
            r_rd_a <= mem_a[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_b) begin
            mem_b[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en && i_ctl.rd_b) begin
            r_rd_b <= mem_b[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_sel_b <= i_ctl.rd_b;
        end
    end

    assign o_rd_data = r_sel_b ? r_rd_b : r_rd_a;

endmodule

`default_nettype wire

// ===== hdl/iddn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iddn_ctrl
// Command sequencer, configuration registers and stencil datapath.
// ---------------------------------------------------------------------------
module iddn_ctrl #(
    parameter int MAX_ROWS  = 512,
    parameter int MAX_COLS  = 512,
    parameter int FRAC_BITS = 12,
    parameter int ADDR_W    = 18,
    parameter int DW        = 20
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    iddn_cmd_if.sink            i_cmd,
    iddn_res_if.source          o_res,
    iddn_cfg_if.sink            i_cfg,
    output iddn_pkg::t_mem_ctl  o_ctl,
    output logic [ADDR_W-1:0]   o_rd_addr,
    output logic [ADDR_W-1:0]   o_wr_addr,
    output logic [DW-1:0]       o_wr_data,
    input  wire  [DW-1:0]       i_rd_data
);
    import iddn_pkg::*;

    localparam int LW = DW + 3;
    localparam int PW = LW + 16;

    typedef enum logic [2:0] {
        S_IDLE, S_RDWAIT, S_ISSUE, S_WAIT, S_MUL, S_WR
    } t_state;

    t_state               r_state;
    logic [KAPPA_W-1:0]   r_kappa;
    logic [ITER_W-1:0]    r_iter;
    logic [SIZE_W-1:0]    r_rows;
    logic [SIZE_W-1:0]    r_cols;
    logic                 r_cur_b;
    logic [SIZE_W-1:0]    r_r;
    logic [SIZE_W-1:0]    r_c;
    logic [ITER_W-1:0]    r_it;
    logic [2:0]           r_k;
    logic                 r_pend;
    logic [2:0]           r_pk;
    logic [DW-1:0]        r_slot [5];
    logic signed [PW-1:0] r_prod;
    logic                 r_ov;
    logic [PIX_W-1:0]     r_pix;
    logic                 r_done;
    logic                 r_err;

    logic [SIZE_W-1:0]    nr, nc;
    logic [KAPPA_W-1:0]   kap;
    logic                 acc, in_range, border, last_px;
    logic [ADDR_W-1:0]    in_addr, at, nb;
    logic signed [LW-1:0] lap;
    logic signed [LW:0]   v;
    logic [DW-1:0]        v_clamp;

    always_comb begin
        nr  = (32'(r_rows) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : r_rows;
        nc  = (32'(r_cols) > MAX_COLS) ? SIZE_W'(MAX_COLS) : r_cols;
        kap = (r_kappa > KAPPA_MAX) ? KAPPA_MAX : r_kappa;
    end

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_ov || o_res.ready);
    assign acc         = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    assign in_range = ({1'b0, i_cmd.row} < nr) && ({1'b0, i_cmd.col} < nc);
    assign in_addr  = ADDR_W'(i_cmd.row) * ADDR_W'(MAX_COLS) + ADDR_W'(i_cmd.col);
    assign at       = ADDR_W'(r_r) * ADDR_W'(MAX_COLS) + ADDR_W'(r_c);

    assign border  = (r_r == '0) || (r_c == '0)
                  || ((11'(r_r) + 11'd1) >= 11'(nr)) || ((11'(r_c) + 11'd1) >= 11'(nc));
    assign last_px = (r_r == nr - SIZE_W'(1)) && (r_c == nc - SIZE_W'(1));

    // Read order of the stencil: center, north, south, west, east.
    always_comb begin
        case (r_k)
            3'd1:    nb = at - ADDR_W'(MAX_COLS);
            3'd2:    nb = at + ADDR_W'(MAX_COLS);
            3'd3:    nb = at - ADDR_W'(1);
            3'd4:    nb = at + ADDR_W'(1);
            default: nb = at;
        endcase
    end

    always_comb begin
        lap = $signed(LW'(r_slot[1])) + $signed(LW'(r_slot[2]))
            + $signed(LW'(r_slot[3])) + $signed(LW'(r_slot[4]))
            - ($signed(LW'(r_slot[0])) <<< 2);
        // The arithmetic shift of the product rounds toward minus infinity.
        v = $signed((LW + 1)'(r_slot[0])) + (LW + 1)'($signed(r_prod[PW-1:16]));
        if (v < 0) begin
            v_clamp = '0;
        end else if (v > $signed((LW + 1)'({DW{1'b1}}))) begin
            v_clamp = '1;
        end else begin
            v_clamp = v[DW-1:0];
        end
    end

    always_comb begin
        o_ctl     = '0;
        o_rd_addr = nb;
        o_wr_addr = at;
        o_wr_data = border ? r_slot[0] : v_clamp;
        if (r_state == S_IDLE) begin
            o_rd_addr = in_addr;
            o_wr_addr = in_addr;
            o_wr_data = {i_cmd.pixel_in, FRAC_BITS'(0)};
            if (acc && in_range && i_cmd.op == OP_LOAD) begin
                o_ctl.wr_en = 1'b1;
                o_ctl.wr_b  = r_cur_b;
            end
            if (acc && in_range && i_cmd.op == OP_READ) begin
                o_ctl.rd_en = 1'b1;
                o_ctl.rd_b  = r_cur_b;
            end
        end else if (r_state == S_ISSUE) begin
            o_ctl.rd_en = 1'b1;
            o_ctl.rd_b  = r_cur_b;
        end else if (r_state == S_WR) begin
            o_ctl.wr_en = 1'b1;
            o_ctl.wr_b  = !r_cur_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_slot[r_pk] <= i_rd_data;
        end
        if (r_state == S_MUL) begin
            r_prod <= lap * $signed({1'b0, kap});
        end
        r_pk <= r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kappa <= KAPPA_RESET;
            r_iter  <= ITER_RESET;
            r_rows  <= SIZE_RESET;
            r_cols  <= SIZE_RESET;
            r_cur_b <= 1'b0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
            r_r     <= '0;
            r_c     <= '0;
            r_it    <= '0;
            r_k     <= '0;
            r_pix   <= '0;
            r_done  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_pend <= (r_state == S_ISSUE);
            if (o_res.valid && o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_KAPPA: r_kappa <= i_cfg.data[KAPPA_W-1:0];
                    CFG_ITER:  r_iter  <= i_cfg.data[ITER_W-1:0];
                    CFG_ROWS:  r_rows  <= i_cfg.data[SIZE_W-1:0];
                    CFG_COLS:  r_cols  <= i_cfg.data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_pix  <= '0;
                        r_done <= 1'b1;
                        r_err  <= 1'b0;
                        if (i_cmd.op == OP_RUN) begin
                            r_r  <= '0;
                            r_c  <= '0;
                            r_it <= '0;
                            r_k  <= '0;
                            if (r_iter == '0) begin
                                r_ov <= 1'b1;
                            end else if (nr == '0 || nc == '0) begin
                                // Empty passes still swap the stores.
                                r_cur_b <= r_cur_b ^ r_iter[0];
                                r_ov    <= 1'b1;
                            end else begin
                                r_state <= S_ISSUE;
                            end
                        end else if (i_cmd.op == OP_LOAD || i_cmd.op == OP_READ) begin
                            r_err <= !in_range;
                            if (i_cmd.op == OP_READ && in_range) begin
                                r_state <= S_RDWAIT;
                            end else begin
                                r_ov <= 1'b1;
                            end
                        end else begin
                            r_done <= 1'b0;
                            r_ov   <= 1'b1;
                        end
                    end
                end
                S_RDWAIT: begin
                    r_pix   <= i_rd_data[DW-1:FRAC_BITS];
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_ISSUE: begin
                    r_k <= r_k + 3'd1;
                    if (border || r_k == 3'd4) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= border ? S_WR : S_MUL;
                end
                S_MUL: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_k     <= '0;
                    r_state <= S_ISSUE;
                    if (r_c == nc - SIZE_W'(1)) begin
                        r_c <= '0;
                        r_r <= r_r + SIZE_W'(1);
                    end else begin
                        r_c <= r_c + SIZE_W'(1);
                    end
                    if (last_px) begin
                        r_cur_b <= !r_cur_b;
                        r_r     <= '0;
                        r_it    <= r_it + ITER_W'(1);
                        if (r_it == r_iter - ITER_W'(1)) begin
                            r_ov    <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.pixel_out  = r_pix;
    assign o_res.done_res   = r_done;
    assign o_res.addr_error = r_err;

endmodule

`default_nettype wire

// ===== tb/sv/iddn_tb_scoreboard.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iddn_tb_scoreboard
// Predicts the results of the denoise unit from its own copy of the frame
// stores and registers, and compares every result beat with the oldest
// expected one.
// ---------------------------------------------------------------------------
typedef struct packed {
    logic [iddn_pkg::PIX_W-1:0] pixel_out;
    logic                       done_res;
    logic                       addr_error;
} iddn_result_t;

class denoise_scoreboard;
    localparam int NCOLS = iddn_pkg::MAX_COLS_DEF;
    localparam int NROWS = iddn_pkg::MAX_ROWS_DEF;
    localparam int FB    = iddn_pkg::FRAC_BITS_DEF;
    localparam longint PIX_CEIL = (longint'(1) << (8 + FB)) - 1;

    int unsigned  store [2][NROWS*NCOLS];
    bit           cur_b;
    int unsigned  kappa, iters, rows, cols;
    iddn_result_t pending_q[$];
    int           errors;
    int           checked;
    int           passes;

    function new();
        cur_b = 0;
        kappa = iddn_pkg::KAPPA_RESET;
        iters = iddn_pkg::ITER_RESET;
        rows  = iddn_pkg::SIZE_RESET;
        cols  = iddn_pkg::SIZE_RESET;
        errors = 0;
        checked = 0;
        passes = 0;
    endfunction

    function void write_reg(logic [iddn_pkg::CIDX_W-1:0] idx,
                            logic [iddn_pkg::CDAT_W-1:0] data);
        case (idx)
            iddn_pkg::CFG_KAPPA: kappa = data[iddn_pkg::KAPPA_W-1:0];
            iddn_pkg::CFG_ITER:  iters = data[iddn_pkg::ITER_W-1:0];
            iddn_pkg::CFG_ROWS:  rows  = data[iddn_pkg::SIZE_W-1:0];
            iddn_pkg::CFG_COLS:  cols  = data[iddn_pkg::SIZE_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned eff_rows();
        return (rows > NROWS) ? NROWS : rows;
    endfunction

    function int unsigned eff_cols();
        return (cols > NCOLS) ? NCOLS : cols;
    endfunction

    function int pending();
        return pending_q.size();
    endfunction

    // One Jacobi pass from the current store into the other one.
    function void diffuse_pass(int unsigned nr, int unsigned nc, longint k);
        int unsigned s, d, at;
        longint u, lap, v;
        s = cur_b;
        d = !cur_b;
        for (int unsigned r = 0; r < nr; r++) begin
            for (int unsigned c = 0; c < nc; c++) begin
                at = r * NCOLS + c;
                if (r == 0 || c == 0 || r + 1 >= nr || c + 1 >= nc) begin
                    store[d][at] = store[s][at];
                end else begin
                    u   = store[s][at];
                    lap = longint'(store[s][at-NCOLS]) + longint'(store[s][at+NCOLS])
                        + longint'(store[s][at-1]) + longint'(store[s][at+1]) - 4 * u;
                    // Arithmetic shift of a signed value rounds toward minus infinity.
                    v = u + ((k * lap) >>> 16);
                    if (v < 0) v = 0;
                    if (v > PIX_CEIL) v = PIX_CEIL;
                    store[d][at] = int'(v);
                end
            end
        end
        cur_b = !cur_b;
        passes++;
    endfunction

    function void note_cmd(logic [iddn_pkg::OP_W-1:0] op, logic [iddn_pkg::ROW_W-1:0] row,
                           logic [iddn_pkg::COL_W-1:0] col, logic [iddn_pkg::PIX_W-1:0] pix);
        iddn_result_t res;
        int unsigned  nr, nc, at, v;
        longint       k;
        res = '0;
        nr = eff_rows();
        nc = eff_cols();
        case (op)
            iddn_pkg::OP_RUN: begin
                k = (kappa > iddn_pkg::KAPPA_MAX) ? iddn_pkg::KAPPA_MAX : kappa;
                for (int unsigned i = 0; i < iters; i++) diffuse_pass(nr, nc, k);
                res.done_res = 1;
            end
            iddn_pkg::OP_LOAD, iddn_pkg::OP_READ: begin
                res.done_res = 1;
                if (row >= nr || col >= nc) begin
                    res.addr_error = 1;
                end else begin
                    at = row * NCOLS + col;
                    if (op == iddn_pkg::OP_LOAD) begin
                        store[cur_b][at] = int'(pix) << FB;
                    end else begin
                        v = store[cur_b][at] >> FB;
                        res.pixel_out = (v > 255) ? 8'd255 : v[7:0];
                    end
                end
            end
            default: ;
        endcase
        pending_q.push_back(res);
    endfunction

    function void check_result(iddn_result_t got);
        iddn_result_t exp_res;
        if (pending_q.size() == 0) begin
            $error("result beat with nothing expected: pixel_out %0d done_res %0d addr_error %0d",
                   got.pixel_out, got.done_res, got.addr_error);
            errors++;
            return;
        end
        exp_res = pending_q.pop_front();
        checked++;
        if (got.pixel_out !== exp_res.pixel_out) begin
            $error("pixel_out: expected %0d, actual %0d", exp_res.pixel_out, got.pixel_out);
            errors++;
        end
        if (got.done_res !== exp_res.done_res) begin
            $error("done_res: expected %0d, actual %0d", exp_res.done_res, got.done_res);
            errors++;
        end
        if (got.addr_error !== exp_res.addr_error) begin
            $error("addr_error: expected %0d, actual %0d", exp_res.addr_error, got.addr_error);
            errors++;
        end
    endfunction

    function void check_leftover();
        if (pending_q.size() != 0) begin
            $error("%0d expected results never arrived", pending_q.size());
            errors++;
        end
    endfunction
endclass

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking test of iso_diffusion_denoise_unit: loads whole frames, runs
// diffusion passes and reads pixels back under random idling on both sides.
// ---------------------------------------------------------------------------
module testbench;
    import iddn_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    logic i_clk;
    logic i_rst_n;

    iddn_cmd_if cmd_if ();
    iddn_res_if res_if ();
    iddn_cfg_if cfg_if ();

    iso_diffusion_denoise_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    denoise_scoreboard sb;
    int idle_mode;     // 0 none, 1 sender, 2 receiver, 3 both
    bit want_hold;
    int hold_left;
    int watch_cnt;
    int cmd_count;
    int run_count;
    int phase_count;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cmd_if.valid = 0;
        cmd_if.op = OP_LOAD;
        cmd_if.row = '0;
        cmd_if.col = '0;
        cmd_if.pixel_in = '0;
        cfg_if.valid = 0;
        cfg_if.index = CFG_KAPPA;
        cfg_if.data = '0;
        res_if.ready = 0;
    end

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Result side: check each beat, then choose the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result('{res_if.pixel_out, res_if.done_res, res_if.addr_error});
        if (want_hold && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            want_hold = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 0;
        end else if (idle_mode == 2) begin
            res_if.ready <= !chance(54);
        end else if (idle_mode == 3) begin
            res_if.ready <= !chance(17);
        end else begin
            res_if.ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            watch_cnt = 0;
        else
            watch_cnt++;
        if (watch_cnt >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("iso_diffusion_denoise_unit test failed");
            $finish;
        end
    end

    task automatic send_cmd(logic [OP_W-1:0] op, int row, int col, int pix);
        int gap;
        gap = 0;
        if (idle_mode == 1 && chance(54)) gap = $urandom_range(1, 4);
        if (idle_mode == 3 && chance(17)) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            cmd_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1;
        cmd_if.op <= op;
        cmd_if.row <= ROW_W'(row);
        cmd_if.col <= COL_W'(col);
        cmd_if.pixel_in <= PIX_W'(pix);
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_cmd(op, ROW_W'(row), COL_W'(col), PIX_W'(pix));
        cmd_count++;
        if (op == OP_RUN) run_count++;
    endtask

    // Stops offering beats and waits until every expected result is back.
    task automatic drain();
        cmd_if.valid <= 0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CIDX_W-1:0] idx, int data);
        cfg_if.valid <= 1;
        cfg_if.index <= idx;
        cfg_if.data <= CDAT_W'(data);
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, CDAT_W'(data));
    endtask

    task automatic configure(int kap, int it, int nr, int nc);
        write_cfg(CFG_KAPPA, kap);
        write_cfg(CFG_ITER, it);
        write_cfg(CFG_ROWS, nr);
        write_cfg(CFG_COLS, nc);
        cfg_if.valid <= 0;
        @(posedge i_clk);
        phase_count++;
    endtask

    // Every pixel of the configured frame is written before any run or read.
    task automatic load_frame();
        for (int r = 0; r < sb.eff_rows(); r++)
            for (int c = 0; c < sb.eff_cols(); c++)
                send_cmd(OP_LOAD, r, c, $urandom_range(0, 255));
    endtask

    task automatic random_items(int count);
        int unsigned nr, nc, pick;
        logic [OP_W-1:0] op;
        for (int i = 0; i < count; i++) begin
            nr = sb.eff_rows();
            nc = sb.eff_cols();
            pick = $urandom_range(0, 99);
            op = chance(50) ? OP_LOAD : OP_READ;
            if (pick < 6) begin
                send_cmd(OP_RUN, $urandom, $urandom, $urandom);
            end else if (pick < 11) begin
                send_cmd(OP_UNKNOWN, $urandom, $urandom, $urandom);
            end else if (pick < 30 || nr == 0 || nc == 0) begin
                send_cmd(op, $urandom_range(0, 511), $urandom_range(0, 511), $urandom);
            end else if (pick < 55) begin
                send_cmd(OP_LOAD, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                         $urandom);
            end else begin
                send_cmd(OP_READ, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                         $urandom);
            end
        end
    endtask

    initial begin
        int kap;
        sb = new();
        idle_mode = 0;
        want_hold = 0;
        hold_left = 0;
        watch_cnt = 0;
        cmd_count = 0;
        run_count = 0;
        phase_count = 0;
        i_rst_n = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: 3x3 frame of extreme values, strongest gain, one pass.
        configure(16384, 1, 3, 3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_cmd(OP_LOAD, r, c, ((r + c) % 2) ? 255 : 0);
        send_cmd(OP_READ, 1, 1, 0);
        send_cmd(OP_RUN, 0, 0, 0);
        send_cmd(OP_READ, 1, 1, 0);
        send_cmd(OP_READ, 0, 1, 0);
        send_cmd(OP_LOAD, 511, 0, 255);
        send_cmd(OP_READ, 0, 511, 0);
        send_cmd(OP_READ, 3, 2, 0);
        send_cmd(OP_UNKNOWN, 511, 511, 255);
        send_cmd(OP_RUN, 511, 511, 255);
        send_cmd(OP_READ, 1, 1, 0);
        drain();

        // Gain above range saturates; longest run count on a 3x3 frame.
        configure(32767, 1023, 3, 3);
        load_frame();
        send_cmd(OP_RUN, 0, 0, 0);
        send_cmd(OP_READ, 1, 1, 0);
        random_items(10);
        drain();

        // Zero gain and zero passes.
        idle_mode = 1;
        configure(0, 0, 4, 4);
        load_frame();
        random_items(20);
        drain();

        // Height above the maximum with a single column; no interior.
        idle_mode = 2;
        configure(16384, 2, 1023, 1);
        load_frame();
        random_items(20);
        drain();

        // A single row; then a degenerate size of zero rows; then two rows.
        idle_mode = 3;
        configure(9000, 1, 1, 24);
        load_frame();
        random_items(20);
        drain();
        configure(1638, 3, 0, 7);
        random_items(20);
        drain();
        configure(12000, 2, 2, 5);
        load_frame();
        random_items(20);
        drain();

        // Random phases on small frames, idling pattern rotating.
        for (int p = 0; p < 4; p++) begin
            idle_mode = p % 4;
            kap = chance(20) ? $urandom_range(16385, 32767) : $urandom_range(0, 16384);
            configure(kap, $urandom_range(0, 4), $urandom_range(3, 9), $urandom_range(3, 9));
            load_frame();
            if (p == 2) want_hold = 1;
            random_items(20);
            drain();
        end

        sb.check_leftover();
        $display("Covered %0d commands (%0d runs, %0d passes) over %0d settings;",
                 cmd_count, run_count, sb.passes, phase_count);
        $display("%0d results compared, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("iso_diffusion_denoise_unit test passed");
        else
            $display("iso_diffusion_denoise_unit test failed");
        $finish;
    end
endmodule
